FILE: rtl/watchdog_power_cycle_supervisor_macros.svh
// ----------------------------------------------------------------------------
// watchdog power cycle supervisor assertion macros
// shared concurrent check helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef WATCHDOG_POWER_CYCLE_SUPERVISOR_MACROS_SVH
`define WATCHDOG_POWER_CYCLE_SUPERVISOR_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define WPCS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define WPCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WPCS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define WPCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: rtl/wpcs_pkg.sv
// ----------------------------------------------------------------------------
// wpcs_pkg
// types and constants shared by the watchdog power cycle supervisor
// ----------------------------------------------------------------------------
package wpcs_pkg;

  localparam int unsigned PrescaleW = 8;
  localparam int unsigned CoarseW   = 5;
  localparam int unsigned TicksW    = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned EventW    = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegPrescaleLimit = 3'd0;
  localparam logic [CfgIdxW-1:0] RegWrapLimit     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTripThreshold = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHoldTicks     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSettleTicks   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTimerRun      = 3'd5;

  // reset values
  localparam logic [PrescaleW-1:0] PrescaleLimitRst = 8'd250;
  localparam logic [CoarseW-1:0]   WrapLimitRst     = 5'd20;
  localparam logic [CoarseW-1:0]   TripThresholdRst = 5'd14;
  localparam logic [TicksW-1:0]    HoldTicksRst     = 16'd150;
  localparam logic [TicksW-1:0]    SettleTicksRst   = 16'd5;

  typedef enum logic [EventW-1:0] {
    EV_NONE       = 3'd0,
    EV_KICKED     = 3'd1,
    EV_TRIPPED    = 3'd2,
    EV_TRIP_DONE  = 3'd3,
    EV_REQ_CONF   = 3'd4,
    EV_REQ_DONE   = 3'd5
  } event_e;

  typedef struct packed {
    logic [PrescaleW-1:0] prescale_limit;
    logic [CoarseW-1:0]   wrap_limit;
    logic [CoarseW-1:0]   trip_threshold;
    logic [TicksW-1:0]    hold_ticks;
    logic [TicksW-1:0]    settle_ticks;
    logic                 timer_run;
  } cfg_t;

  typedef struct packed {
    logic   power_enable;
    logic   display_enable;
    event_e event_code;
  } result_t;

endpackage

FILE: rtl/watchdog_power_cycle_supervisor.sv
// ----------------------------------------------------------------------------
// watchdog_power_cycle_supervisor
// external watchdog and supply/display power cycle sequencer
// ----------------------------------------------------------------------------
// usage:
//   each word on s_axis is one base tick (kick flag, watchdog enable pin,
//   power-off request pin). every tick gives exactly one word on m_axis
//   with the supply and display enable levels and an event code.
//   the cfg channel writes one register per handshake, index 0..5;
//   it is always ready and is meant to be used while no tick is in flight.
//   latency: the result word is valid the cycle after the tick is taken.
//   throughput: one tick per cycle while the receiver keeps up; the whole
//   update is a single pass of counter and phase logic between the input
//   handshake and the result register.
//   a stalled receiver holds the result register; s_axis_tready stays high
//   as long as that register is empty or being emptied in the same cycle.
//   reset loads the register defaults and starts the power-up sequence
//   (supply off for settle_ticks ticks, then display off for hold_ticks).
// ----------------------------------------------------------------------------
`include "watchdog_power_cycle_supervisor_macros.svh"

module watchdog_power_cycle_supervisor #(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // cfg write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wpcs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [wpcs_pkg::CfgDataW-1:0]  cfg_data_i,
  // tick stream in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // kick, wdt_enable_n, pwroff_n, 0 pad
  // result stream out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata   // power_enable, display_enable,
                                                        // event_code[2:0], 0 pad
);

  wpcs_pkg::cfg_t    cfg;
  wpcs_pkg::result_t step_res;
  wpcs_pkg::result_t out_res;
  logic              in_fire;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !m_axis_tvalid | m_axis_tready;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  wpcs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  wpcs_core #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (in_fire),
    .kick_i         (s_axis_tdata[0]),
    .wdt_enable_n_i (s_axis_tdata[1]),
    .pwroff_n_i     (s_axis_tdata[2]),
    .cfg_i          (cfg),
    .res_o          (step_res)
  );

  wpcs_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_fire),
    .res_i   (step_res),
    .take_i  (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {3'b000, out_res.event_code, out_res.display_enable,
                         out_res.power_enable};

  // display never on without the supply
  `WPCS_ASSERT_SAME(a_disp_needs_power, clk_i, rst_ni, m_axis_tvalid,
    !(out_res.display_enable && !out_res.power_enable), "display on with supply off")
  // every accepted tick produces a result word
  `WPCS_ASSERT_NEXT(a_tick_gives_word, clk_i, rst_ni, in_fire, m_axis_tvalid,
    "accepted tick produced no result")
  // a trip or confirmed request always drops both enables
  `WPCS_ASSERT_SAME(a_cycle_starts_off, clk_i, rst_ni,
    m_axis_tvalid && (out_res.event_code == wpcs_pkg::EV_TRIPPED ||
                      out_res.event_code == wpcs_pkg::EV_REQ_CONF),
    !out_res.power_enable && !out_res.display_enable, "power cycle did not start off")

endmodule

FILE: rtl/wpcs_cfg.sv
// ----------------------------------------------------------------------------
// wpcs_cfg
// configuration register file, one write per handshake
// ----------------------------------------------------------------------------
module wpcs_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [wpcs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [wpcs_pkg::CfgDataW-1:0]  cfg_data_i,
  output wpcs_pkg::cfg_t                 cfg_o
);

  wpcs_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wpcs_pkg::RegPrescaleLimit:
          cfg_d.prescale_limit = cfg_data_i[wpcs_pkg::PrescaleW-1:0];
        wpcs_pkg::RegWrapLimit:     cfg_d.wrap_limit = cfg_data_i[wpcs_pkg::CoarseW-1:0];
        wpcs_pkg::RegTripThreshold: cfg_d.trip_threshold = cfg_data_i[wpcs_pkg::CoarseW-1:0];
        wpcs_pkg::RegHoldTicks:     cfg_d.hold_ticks = cfg_data_i[wpcs_pkg::TicksW-1:0];
        wpcs_pkg::RegSettleTicks:   cfg_d.settle_ticks = cfg_data_i[wpcs_pkg::TicksW-1:0];
        wpcs_pkg::RegTimerRun:      cfg_d.timer_run = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prescale_limit <= wpcs_pkg::PrescaleLimitRst;
      cfg_q.wrap_limit     <= wpcs_pkg::WrapLimitRst;
      cfg_q.trip_threshold <= wpcs_pkg::TripThresholdRst;
      cfg_q.hold_ticks     <= wpcs_pkg::HoldTicksRst;
      cfg_q.settle_ticks   <= wpcs_pkg::SettleTicksRst;
      cfg_q.timer_run      <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/wpcs_core.sv
// ----------------------------------------------------------------------------
// wpcs_core
// per-tick state update: prescaler, coarse counter, wait timer, phase
// ----------------------------------------------------------------------------
module wpcs_core #(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                kick_i,
  input  logic                wdt_enable_n_i,
  input  logic                pwroff_n_i,
  input  wpcs_pkg::cfg_t      cfg_i,
  output wpcs_pkg::result_t   res_o
);

  localparam int unsigned LimW = (DELAY_WIDTH > wpcs_pkg::TicksW) ?
                                 DELAY_WIDTH : wpcs_pkg::TicksW;
  localparam logic [DELAY_WIDTH-1:0] DelayMax = {DELAY_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    PH_START_WAIT = 3'd0,
    PH_START_DISP = 3'd1,
    PH_RUN        = 3'd2,
    PH_OFF_HOLD   = 3'd3,
    PH_ON_HOLD    = 3'd4,
    PH_CHECK1     = 3'd5,
    PH_CHECK2     = 3'd6
  } phase_e;

  phase_e                            phase_q, phase_d;
  logic [wpcs_pkg::PrescaleW-1:0]    pre_q, pre_d;
  logic [wpcs_pkg::CoarseW-1:0]      coarse_q, coarse_d;
  logic [DELAY_WIDTH-1:0]            delay_q, delay_d;
  logic                              kick_pend_q, kick_pend_d;
  logic                              cause_q, cause_d;

  logic                              startup;
  logic [wpcs_pkg::TicksW-1:0]       wait_len;
  logic [LimW-1:0]                   len_ext, lim_ext;
  logic [DELAY_WIDTH-1:0]            lim;
  logic [DELAY_WIDTH-1:0]            delay_inc;
  logic                              wait_done;
  logic [wpcs_pkg::PrescaleW-1:0]    pre_inc;
  logic [wpcs_pkg::CoarseW-1:0]      coarse_inc;
  wpcs_pkg::event_e                  ev;

  assign startup = (phase_q == PH_START_WAIT) || (phase_q == PH_START_DISP);

  // wait timer: length clamped to the counter range, zero counts as one
  always_comb begin
    case (phase_q)
      PH_START_WAIT, PH_CHECK1, PH_CHECK2: wait_len = cfg_i.settle_ticks;
      default:                             wait_len = cfg_i.hold_ticks;
    endcase
    len_ext = LimW'(wait_len);
    lim_ext = (len_ext > LimW'(DelayMax)) ? LimW'(DelayMax) : len_ext;
    lim     = lim_ext[DELAY_WIDTH-1:0];
    if (lim == '0) lim = DELAY_WIDTH'(1);
    delay_inc = (delay_q < DelayMax) ? delay_q + DELAY_WIDTH'(1) : delay_q;
    wait_done = (delay_inc >= lim);
  end

  always_comb begin
    phase_d     = phase_q;
    pre_d       = pre_q;
    coarse_d    = coarse_q;
    delay_d     = delay_q;
    kick_pend_d = kick_pend_q | (!startup & kick_i);
    cause_d     = cause_q;
    ev          = wpcs_pkg::EV_NONE;
    pre_inc     = pre_q + wpcs_pkg::PrescaleW'(1);
    coarse_inc  = coarse_q + wpcs_pkg::CoarseW'(1);

    if (startup) begin
      pre_d    = '0;
      coarse_d = '0;
    end else if (cfg_i.timer_run) begin
      pre_d = pre_inc;
      if (pre_inc >= cfg_i.prescale_limit) begin
        pre_d    = '0;
        coarse_d = (coarse_inc >= cfg_i.wrap_limit) ? '0 : coarse_inc;
      end
    end

    unique case (phase_q)
      PH_START_WAIT: begin
        delay_d = wait_done ? '0 : delay_inc;
        if (wait_done) phase_d = PH_START_DISP;
      end
      PH_START_DISP: begin
        delay_d = wait_done ? '0 : delay_inc;
        if (wait_done) begin
          pre_d    = '0;
          coarse_d = '0;
          phase_d  = PH_RUN;
        end
      end
      PH_OFF_HOLD: begin
        delay_d = wait_done ? '0 : delay_inc;
        if (wait_done) phase_d = PH_ON_HOLD;
      end
      PH_ON_HOLD: begin
        delay_d = wait_done ? '0 : delay_inc;
        if (wait_done) begin
          pre_d    = '0;
          coarse_d = '0;
          ev       = cause_q ? wpcs_pkg::EV_REQ_DONE : wpcs_pkg::EV_TRIP_DONE;
          phase_d  = PH_RUN;
        end
      end
      PH_CHECK1: begin
        delay_d = wait_done ? '0 : delay_inc;
        if (wait_done) phase_d = pwroff_n_i ? PH_RUN : PH_CHECK2;
      end
      PH_CHECK2: begin
        delay_d = wait_done ? '0 : delay_inc;
        if (wait_done) begin
          if (pwroff_n_i) begin
            phase_d = PH_RUN;
          end else begin
            ev      = wpcs_pkg::EV_REQ_CONF;
            cause_d = 1'b1;
            phase_d = PH_OFF_HOLD;
          end
        end
      end
      default: begin
        // run, and any unused phase code
        phase_d = PH_RUN;
        delay_d = '0;
        if (kick_pend_d) begin
          pre_d       = '0;
          coarse_d    = '0;
          kick_pend_d = 1'b0;
          ev          = wpcs_pkg::EV_KICKED;
        end
        if (!wdt_enable_n_i && (coarse_d >= cfg_i.trip_threshold)) begin
          ev      = wpcs_pkg::EV_TRIPPED;
          cause_d = 1'b0;
          phase_d = PH_OFF_HOLD;
        end else if (!pwroff_n_i) begin
          phase_d = PH_CHECK1;
        end
      end
    endcase
  end

  // output levels follow the phase after this tick
  always_comb begin
    res_o.event_code = ev;
    case (phase_d)
      PH_START_WAIT, PH_OFF_HOLD: begin
        res_o.power_enable   = 1'b0;
        res_o.display_enable = 1'b0;
      end
      PH_START_DISP, PH_ON_HOLD: begin
        res_o.power_enable   = 1'b1;
        res_o.display_enable = 1'b0;
      end
      default: begin
        res_o.power_enable   = 1'b1;
        res_o.display_enable = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START_WAIT;
      pre_q       <= '0;
      coarse_q    <= '0;
      delay_q     <= '0;
      kick_pend_q <= 1'b0;
      cause_q     <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      pre_q       <= pre_d;
      coarse_q    <= coarse_d;
      delay_q     <= delay_d;
      kick_pend_q <= kick_pend_d;
      cause_q     <= cause_d;
    end
  end

endmodule

FILE: rtl/wpcs_out_reg.sv
// ----------------------------------------------------------------------------
// wpcs_out_reg
// result register between the tick update and the output stream
// ----------------------------------------------------------------------------
module wpcs_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  wpcs_pkg::result_t   res_i,
  input  logic                take_i,
  output logic                valid_o,
  output wpcs_pkg::result_t   res_o
);

  logic              valid_q, valid_d;
  wpcs_pkg::result_t res_q;

  // a new word may replace one that is taken in the same cycle
  assign valid_d = load_i | (valid_q & !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: tb/watchdog_power_cycle_supervisor_checker.sv
// ----------------------------------------------------------------------------
// watchdog power cycle supervisor checker
// follows the config and tick channels, predicts the supply/display levels
// and event code for every tick, and compares each result word in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module watchdog_power_cycle_supervisor_checker #(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [wpcs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [wpcs_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           tick_valid_i,
  input  logic                           tick_ready_i,
  input  logic [7:0]                     tick_data_i,   // kick, wdt_enable_n, pwroff_n, 0 pad
  input  logic                           res_valid_i,
  input  logic                           res_ready_i,
  input  logic [7:0]                     res_data_i,    // power_enable, display_enable,
                                                        // event_code[2:0], 0 pad
  output int unsigned                    errors_o,
  output int unsigned                    pending_o,
  output int unsigned                    checked_o,
  output int unsigned                    trips_o,
  output int unsigned                    confirms_o
);

  import wpcs_pkg::*;

  typedef enum logic [2:0] {
    PH_PWR_WAIT   = 3'd0,
    PH_DISP_WAIT  = 3'd1,
    PH_RUN        = 3'd2,
    PH_OFF_HOLD   = 3'd3,
    PH_ON_HOLD    = 3'd4,
    PH_REQ_CHECK1 = 3'd5,
    PH_REQ_CHECK2 = 3'd6
  } sup_phase_e;

  cfg_t                   cfg_q;
  sup_phase_e             phase_q;
  logic [PrescaleW-1:0]   prescale_cnt;
  logic [CoarseW-1:0]     coarse_cnt;
  logic [DELAY_WIDTH-1:0] delay_cnt;
  logic                   kick_pend;
  logic                   cause_req;

  result_t     expected_levels_q[$];
  result_t     exp_r;
  int unsigned err_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned trip_cnt = 0;
  int unsigned confirm_cnt = 0;

  task automatic note_mismatch(input string msg);
    if (err_cnt < 10) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    err_cnt++;
  endtask

  function automatic void enter_phase(input sup_phase_e p);
    phase_q   = p;
    delay_cnt = '0;
  endfunction

  function automatic void clear_counters();
    prescale_cnt = '0;
    coarse_cnt   = '0;
  endfunction

  // one tick of a wait; a zero length counts as one, long ones saturate
  function automatic logic wait_over(input logic [TicksW-1:0] len);
    longint unsigned ceiling;
    longint unsigned lim;
    ceiling = (64'd1 << DELAY_WIDTH) - 64'd1;
    lim = 64'(len);
    if (lim > ceiling) lim = ceiling;
    if (lim == 64'd0) lim = 64'd1;
    if (64'(delay_cnt) < ceiling) delay_cnt = delay_cnt + DELAY_WIDTH'(1);
    if (64'(delay_cnt) >= lim) begin
      delay_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t predict_tick(input logic kick, input logic wdt_en_n,
                                           input logic pwroff_n);
    result_t r;
    event_e  ev;
    logic    startup;
    ev = EV_NONE;
    startup = (phase_q == PH_PWR_WAIT) || (phase_q == PH_DISP_WAIT);

    if (!startup && kick) kick_pend = 1'b1;

    if (startup) begin
      clear_counters();
    end else if (cfg_q.timer_run) begin
      prescale_cnt = prescale_cnt + PrescaleW'(1);
      if (prescale_cnt >= cfg_q.prescale_limit) begin
        prescale_cnt = '0;
        coarse_cnt = coarse_cnt + CoarseW'(1);
        if (coarse_cnt >= cfg_q.wrap_limit) coarse_cnt = '0;
      end
    end

    case (phase_q)
      PH_PWR_WAIT: begin
        if (wait_over(cfg_q.settle_ticks)) enter_phase(PH_DISP_WAIT);
      end
      PH_DISP_WAIT: begin
        if (wait_over(cfg_q.hold_ticks)) begin
          clear_counters();
          enter_phase(PH_RUN);
        end
      end
      PH_OFF_HOLD: begin
        if (wait_over(cfg_q.hold_ticks)) enter_phase(PH_ON_HOLD);
      end
      PH_ON_HOLD: begin
        if (wait_over(cfg_q.hold_ticks)) begin
          clear_counters();
          ev = cause_req ? EV_REQ_DONE : EV_TRIP_DONE;
          enter_phase(PH_RUN);
        end
      end
      PH_REQ_CHECK1: begin
        if (wait_over(cfg_q.settle_ticks)) begin
          enter_phase(pwroff_n ? PH_RUN : PH_REQ_CHECK2);
        end
      end
      PH_REQ_CHECK2: begin
        if (wait_over(cfg_q.settle_ticks)) begin
          if (pwroff_n) begin
            enter_phase(PH_RUN);
          end else begin
            ev = EV_REQ_CONF;
            cause_req = 1'b1;
            enter_phase(PH_OFF_HOLD);
          end
        end
      end
      default: begin
        enter_phase(PH_RUN);
        if (kick_pend) begin
          clear_counters();
          kick_pend = 1'b0;
          ev = EV_KICKED;
        end
        // a kick in the same tick has already cleared the coarse count
        if (!wdt_en_n && coarse_cnt >= cfg_q.trip_threshold) begin
          ev = EV_TRIPPED;
          cause_req = 1'b0;
          enter_phase(PH_OFF_HOLD);
        end else if (!pwroff_n) begin
          enter_phase(PH_REQ_CHECK1);
        end
      end
    endcase

    case (phase_q)
      PH_PWR_WAIT, PH_OFF_HOLD: begin
        r.power_enable   = 1'b0;
        r.display_enable = 1'b0;
      end
      PH_DISP_WAIT, PH_ON_HOLD: begin
        r.power_enable   = 1'b1;
        r.display_enable = 1'b0;
      end
      default: begin
        r.power_enable   = 1'b1;
        r.display_enable = 1'b1;
      end
    endcase
    r.event_code = ev;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prescale_limit = PrescaleLimitRst;
      cfg_q.wrap_limit     = WrapLimitRst;
      cfg_q.trip_threshold = TripThresholdRst;
      cfg_q.hold_ticks     = HoldTicksRst;
      cfg_q.settle_ticks   = SettleTicksRst;
      cfg_q.timer_run      = 1'b1;
      phase_q      = PH_PWR_WAIT;
      prescale_cnt = '0;
      coarse_cnt   = '0;
      delay_cnt    = '0;
      kick_pend    = 1'b0;
      cause_req    = 1'b0;
      expected_levels_q.delete();
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (expected_levels_q.size() == 0) begin
          note_mismatch($sformatf("result word %h with no tick outstanding", res_data_i));
        end else begin
          exp_r = expected_levels_q.pop_front();
          checked_cnt++;
          if (res_data_i[0] !== exp_r.power_enable) begin
            note_mismatch($sformatf("power_enable expected %0b got %0b",
                                    exp_r.power_enable, res_data_i[0]));
          end
          if (res_data_i[1] !== exp_r.display_enable) begin
            note_mismatch($sformatf("display_enable expected %0b got %0b",
                                    exp_r.display_enable, res_data_i[1]));
          end
          if (res_data_i[4:2] !== exp_r.event_code) begin
            note_mismatch($sformatf("event_code expected %0d got %0d",
                                    exp_r.event_code, res_data_i[4:2]));
          end
          if (res_data_i[7:5] !== 3'b000) begin
            note_mismatch($sformatf("pad bits expected 0 got %b", res_data_i[7:5]));
          end
        end
      end

      if (tick_valid_i && tick_ready_i) begin
        exp_r = predict_tick(tick_data_i[0], tick_data_i[1], tick_data_i[2]);
        if (exp_r.event_code == EV_TRIPPED) trip_cnt++;
        if (exp_r.event_code == EV_REQ_CONF) confirm_cnt++;
        expected_levels_q.push_back(exp_r);
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegPrescaleLimit: cfg_q.prescale_limit = cfg_data_i[PrescaleW-1:0];
          RegWrapLimit:     cfg_q.wrap_limit     = cfg_data_i[CoarseW-1:0];
          RegTripThreshold: cfg_q.trip_threshold = cfg_data_i[CoarseW-1:0];
          RegHoldTicks:     cfg_q.hold_ticks     = cfg_data_i[TicksW-1:0];
          RegSettleTicks:   cfg_q.settle_ticks   = cfg_data_i[TicksW-1:0];
          RegTimerRun:      cfg_q.timer_run      = cfg_data_i[0];
          default: ;
        endcase
      end
    end
    errors_o   <= err_cnt;
    pending_o  <= expected_levels_q.size();
    checked_o  <= checked_cnt;
    trips_o    <= trip_cnt;
    confirms_o <= confirm_cnt;
  end

endmodule

FILE: tb/watchdog_power_cycle_supervisor_tb.sv
// ----------------------------------------------------------------------------
// watchdog power cycle supervisor testbench
// drives tick words and register writes with random gaps and receiver
// stalls; a checker beside the block predicts and compares every result word
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module watchdog_power_cycle_supervisor_tb;

  import wpcs_pkg::*;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;

  int unsigned errors, pending, checked, trips, confirms;

  // tick pattern state
  int unsigned ticks_sent    = 0;
  int unsigned settings_used = 0;
  int unsigned cur_settle    = 5;
  int unsigned stretch_left  = 0;
  int unsigned kick_pct      = 0;
  int unsigned tx_gap_pct    = 0;
  logic        wdt_level     = 1'b0;
  logic        pwr_level     = 1'b1;
  int unsigned pwr_left      = 20;

  // receiver stall state
  int unsigned rx_mode_left  = 0;
  int unsigned rx_stall_left = 0;
  int unsigned rx_stall_pct  = 0;

  watchdog_power_cycle_supervisor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  watchdog_power_cycle_supervisor_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .tick_valid_i (s_axis_tvalid),
    .tick_ready_i (s_axis_tready),
    .tick_data_i  (s_axis_tdata),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .errors_o     (errors),
    .pending_o    (pending),
    .checked_o    (checked),
    .trips_o      (trips),
    .confirms_o   (confirms)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned gap_len();
    if ($urandom_range(99) < 85) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  function automatic logic [2:0] tick_word(input logic kick, input logic wdt_en_n,
                                           input logic pwroff_n);
    return {pwroff_n, wdt_en_n, kick};
  endfunction

  // receiver: stall density changes now and then, sometimes no stalls at all
  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode_left <= $urandom_range(300, 40);
      case ($urandom_range(2))
        0: rx_stall_pct <= 0;
        1: rx_stall_pct <= 15;
        default: rx_stall_pct <= 50;
      endcase
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    if (rx_stall_left != 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if ($urandom_range(99) < rx_stall_pct) begin
      m_axis_tready <= 1'b0;
      rx_stall_left <= gap_len() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_tick(input logic [2:0] w, input int unsigned gap);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b00000, w};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ticks_sent++;
  endtask

  // hold the sender until every tick has its result word back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_config(input int unsigned ps, input int unsigned wr,
                              input int unsigned tr, input int unsigned hd,
                              input int unsigned st, input int unsigned tm);
    logic [CfgIdxW-1:0]  idx [6];
    logic [CfgDataW-1:0] val [6];
    idx[0] = RegPrescaleLimit;  val[0] = CfgDataW'(ps);
    idx[1] = RegWrapLimit;      val[1] = CfgDataW'(wr);
    idx[2] = RegTripThreshold;  val[2] = CfgDataW'(tr);
    idx[3] = RegHoldTicks;      val[3] = CfgDataW'(hd);
    idx[4] = RegSettleTicks;    val[4] = CfgDataW'(st);
    idx[5] = RegTimerRun;       val[5] = CfgDataW'(tm);
    for (int i = 0; i < 6; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    cur_settle = st;
    settings_used++;
  endtask

  // stretches of steady kick rate and enable pin; request pin low in runs
  // that sometimes clear a confirmation and sometimes fall short
  task automatic next_word(output logic [2:0] w, output int unsigned gap);
    int unsigned low_max;
    logic        kick;
    logic        pwroff;
    if (stretch_left == 0) begin
      stretch_left = $urandom_range(150, 30);
      case ($urandom_range(2))
        0: kick_pct = 0;
        1: kick_pct = 3;
        default: kick_pct = 30;
      endcase
      case ($urandom_range(2))
        0: tx_gap_pct = 0;
        1: tx_gap_pct = 15;
        default: tx_gap_pct = 50;
      endcase
      wdt_level = ($urandom_range(4) == 0);
    end
    stretch_left--;
    if (pwr_left == 0) begin
      pwr_level = !pwr_level;
      if (pwr_level) begin
        pwr_left = $urandom_range(80, 5);
      end else begin
        low_max = 3 * cur_settle + 4;
        if (low_max > 60 || $urandom_range(4) == 0) low_max = 60;
        pwr_left = $urandom_range(low_max, 1);
      end
    end
    pwr_left--;
    kick   = ($urandom_range(99) < kick_pct);
    pwroff = pwr_level;
    if ($urandom_range(99) < 10) begin
      kick   = 1'($urandom_range(1));
      pwroff = 1'($urandom_range(1));
    end
    w   = tick_word(kick, wdt_level, pwroff);
    gap = ($urandom_range(99) < tx_gap_pct) ? gap_len() : 0;
  endtask

  task automatic run_phase(input int unsigned ps, input int unsigned wr,
                           input int unsigned tr, input int unsigned hd,
                           input int unsigned st, input int unsigned tm,
                           input int unsigned n);
    logic [2:0]  w;
    int unsigned gap;
    wait_idle();
    write_config(ps, wr, tr, hd, st, tm);
    for (int i = 0; i < n; i++) begin
      next_word(w, gap);
      send_tick(w, gap);
      if ($urandom_range(199) == 0) wait_idle();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // short waits so every phase is reached within a few ticks
    write_config(1, 4, 2, 2, 2, 1);
    // power-up: kicks and a low request are ignored
    send_tick(tick_word(1'b1, 1'b0, 1'b1), 0);
    send_tick(tick_word(1'b1, 1'b0, 1'b0), 0);
    send_tick(tick_word(1'b0, 1'b1, 1'b1), 0);
    send_tick(tick_word(1'b1, 1'b0, 1'b1), 0);
    // threshold passed while disabled, then a kick beats the trip
    send_tick(tick_word(1'b0, 1'b1, 1'b1), 0);
    send_tick(tick_word(1'b0, 1'b1, 1'b1), 0);
    send_tick(tick_word(1'b1, 1'b0, 1'b1), 0);
    // trip, with a kick held pending across the cycle
    send_tick(tick_word(1'b0, 1'b0, 1'b1), 0);
    send_tick(tick_word(1'b0, 1'b0, 1'b1), 0);
    send_tick(tick_word(1'b1, 1'b0, 1'b1), 0);
    send_tick(tick_word(1'b0, 1'b0, 1'b0), 0);
    send_tick(tick_word(1'b0, 1'b0, 1'b1), 0);
    send_tick(tick_word(1'b0, 1'b1, 1'b1), 0);
    send_tick(tick_word(1'b0, 1'b1, 1'b1), 0);
    // request held low: confirmed cycle, then it starts checking again
    for (int i = 0; i < 12; i++) send_tick(tick_word(1'b0, 1'b1, 1'b0), 0);
    // released during the second check
    send_tick(tick_word(1'b0, 1'b1, 1'b1), 0);
    send_tick(tick_word(1'b0, 1'b1, 1'b1), 0);

    run_phase(1, 31, 31, 1, 1, 1, 200);
    run_phase(2, 8, 5, 3, 2, 1, 350);
    run_phase(3, 12, 4, 4, 3, 0, 150);
    run_phase(255, 1, 1, 2, 1, 1, 150);
    run_phase(1, 6, 5, 5, 4, 1, 300);
    run_phase(4, 20, 3, 2, 2, 1, 200);
    run_phase(255, 31, 31, 65535, 65535, 1, 60);

    wait_idle();
    repeat (4) @(posedge clk_i);
    $display("covered %0d ticks under %0d register settings, %0d result words checked",
             ticks_sent, settings_used, checked);
    $display("watchdog trips %0d, confirmed power-off requests %0d", trips, confirms);
    if (errors == 0 && pending == 0) begin
      $display("watchdog_power_cycle_supervisor_tb: clean");
    end else begin
      $display("watchdog_power_cycle_supervisor_tb: errors");
    end
    $finish;
  end

  initial begin
    #(64'd5_000_000);
    $display("timeout with %0d result words outstanding", pending);
    $display("watchdog_power_cycle_supervisor_tb: errors");
    $finish;
  end

endmodule
